/* hw/rtl/rcp_pkg.sv */
`default_nettype none

package rcp_pkg;

    localparam int LEN_BITS = 16;
    localparam int KEY_BITS = 64;
    localparam int SEEN_BITS = 16;

    typedef enum logic [3:0] {
        PH_CNT      = 4'd0,
        PH_TLEN     = 4'd1,
        PH_TYPE     = 4'd2,
        PH_TYPE_END = 4'd3,
        PH_KLEN     = 4'd4,
        PH_KEY      = 4'd5,
        PH_KEY_END  = 4'd6,
        PH_VLEN     = 4'd7,
        PH_VAL      = 4'd8,
        PH_VAL_END  = 4'd9
    } phase_t;

    localparam logic [1:0] SUB_START  = 2'd0;
    localparam logic [1:0] SUB_DIGITS = 2'd1;
    localparam logic [1:0] SUB_CR     = 2'd2;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_PEND = 2'd2;

    localparam logic [1:0] CMD_UNKNOWN = 2'd0;
    localparam logic [1:0] CMD_SET     = 2'd1;
    localparam logic [1:0] CMD_GET     = 2'd2;
    localparam logic [1:0] CMD_DEL     = 2'd3;

    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       chunk_last;
        logic [7:0] conn_tag;
    } in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  value_byte;
        logic [1:0]  cmd_type;
        logic [63:0] key_number;
        logic [15:0] arg_count;
        logic [15:0] value_length;
        logic [7:0]  out_tag;
    } out_t;

    typedef struct packed {
        logic valid;
        out_t data;
    } res_t;

    // letters of SET, GET and DEL
    function automatic logic [7:0] type_char(input logic [1:0] word, input logic [1:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (pos)
            2'd0: begin
                case (word)
                    2'd0: c = 8'h53;
                    2'd1: c = 8'h47;
                    2'd2: c = 8'h44;
                    default: c = 8'h00;
                endcase
            end
            2'd1: c = 8'h45;
            2'd2: begin
                case (word)
                    2'd2: c = 8'h4c;
                    default: c = 8'h54;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/rcp_in_stage.sv */
`default_nettype none

module rcp_in_stage (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire rcp_pkg::in_t s_payload,
    input  wire logic        advance,
    output logic             item_valid,
    output rcp_pkg::in_t     item
);

    logic         valid_reg;
    rcp_pkg::in_t data_reg;

    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            data_reg <= s_payload;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rcp_core.sv */
`default_nettype none

module rcp_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         step,
    input  wire rcp_pkg::in_t item,
    output rcp_pkg::res_t     res
);

    localparam int LB = rcp_pkg::LEN_BITS;
    localparam int KB = rcp_pkg::KEY_BITS;
    localparam int SB = rcp_pkg::SEEN_BITS;

    typedef struct packed {
        logic          done;
        logic [LB-1:0] accum;
        logic [LB-1:0] sub;
    } len_step_t;

    function automatic logic [LB-1:0] add_digit(input logic [LB-1:0] a, input logic [7:0] b);
        return (a << 3) + (a << 1) + LB'(b) - LB'(rcp_pkg::CH_ZERO);
    endfunction

    function automatic len_step_t len_step(input logic [LB-1:0] accum,
                                           input logic [LB-1:0] sub,
                                           input logic [7:0] b,
                                           input logic [7:0] marker);
        len_step_t r;
        r.done  = 1'b0;
        r.accum = accum;
        r.sub   = sub;
        if (sub == LB'(rcp_pkg::SUB_START)) begin
            if (b == rcp_pkg::CH_LF) begin
                r.done = 1'b1;
            end else if (b == marker) begin
                r.sub = LB'(rcp_pkg::SUB_DIGITS);
            end else if (b == rcp_pkg::CH_CR) begin
                r.sub = LB'(rcp_pkg::SUB_CR);
            end else begin
                r.accum = add_digit(accum, b);
                r.sub   = LB'(rcp_pkg::SUB_DIGITS);
            end
        end else if (b == rcp_pkg::CH_CR) begin
            r.sub = LB'(rcp_pkg::SUB_CR);
        end else if (sub == LB'(rcp_pkg::SUB_CR) && b == rcp_pkg::CH_LF) begin
            r.done = 1'b1;
        end else begin
            r.accum = add_digit(accum, b);
            r.sub   = LB'(rcp_pkg::SUB_DIGITS);
        end
        return r;
    endfunction

    rcp_pkg::phase_t phase_reg, phase_next;
    logic [LB-1:0]   accum_reg, accum_next;
    logic [LB-1:0]   left_reg, left_next;
    logic [KB-1:0]   key_reg, key_next;
    logic [2:0]      match_reg, match_next;
    logic [SB-1:0]   seen_reg, seen_next;
    logic [LB-1:0]   count_reg, count_next;
    logic [LB-1:0]   vlen_reg, vlen_next;
    logic [1:0]      type_reg, type_next;

    len_step_t       ls;
    logic [LB-1:0]   len_accum_in;
    logic [LB-1:0]   len_sub_in;
    logic [7:0]      marker;
    logic [LB-1:0]   left_dec;
    logic [KB-1:0]   key_plus;
    logic [1:0]      type_found;
    logic            is_digit;
    logic            do_complete;
    logic [KB-1:0]   done_key;

    assign left_dec = left_reg - LB'(1);
    assign key_plus = key_reg + KB'(1);
    assign is_digit = item.in_byte >= rcp_pkg::CH_ZERO && item.in_byte <= rcp_pkg::CH_NINE;

    always_comb begin
        if (seen_reg != SB'(3)) begin
            type_found = rcp_pkg::CMD_UNKNOWN;
        end else if (match_reg[0]) begin
            type_found = rcp_pkg::CMD_SET;
        end else if (match_reg[1]) begin
            type_found = rcp_pkg::CMD_GET;
        end else if (match_reg[2]) begin
            type_found = rcp_pkg::CMD_DEL;
        end else begin
            type_found = rcp_pkg::CMD_UNKNOWN;
        end
    end

    // shared length-field step; unused phase codes restart from a clean field
    always_comb begin
        marker       = rcp_pkg::CH_DOLLAR;
        len_accum_in = accum_reg;
        len_sub_in   = left_reg;
        case (phase_reg)
            rcp_pkg::PH_TLEN, rcp_pkg::PH_KLEN, rcp_pkg::PH_VLEN: begin
                marker = rcp_pkg::CH_DOLLAR;
            end
            rcp_pkg::PH_CNT: begin
                marker = rcp_pkg::CH_STAR;
            end
            default: begin
                marker       = rcp_pkg::CH_STAR;
                len_accum_in = '0;
                len_sub_in   = LB'(rcp_pkg::SUB_START);
            end
        endcase
        ls = len_step(len_accum_in, len_sub_in, item.in_byte, marker);
    end

    // state update
    always_comb begin
        phase_next  = phase_reg;
        accum_next  = accum_reg;
        left_next   = left_reg;
        key_next    = key_reg;
        match_next  = match_reg;
        seen_next   = seen_reg;
        count_next  = count_reg;
        vlen_next   = vlen_reg;
        type_next   = type_reg;
        do_complete = 1'b0;
        done_key    = key_reg;
        case (phase_reg)
            rcp_pkg::PH_TLEN: begin
                accum_next = ls.accum;
                left_next  = ls.sub;
                if (ls.done) begin
                    left_next  = ls.accum;
                    seen_next  = '0;
                    match_next = 3'b111;
                    phase_next = (ls.accum != '0) ? rcp_pkg::PH_TYPE : rcp_pkg::PH_TYPE_END;
                end
            end
            rcp_pkg::PH_TYPE: begin
                if (seen_reg < SB'(3)) begin
                    for (int i = 0; i < 3; i++) begin
                        if (rcp_pkg::type_char(2'(i), seen_reg[1:0]) != item.in_byte) begin
                            match_next[i] = 1'b0;
                        end
                    end
                end
                if (seen_reg != '1) begin
                    seen_next = seen_reg + SB'(1);
                end
                left_next = left_dec;
                if (left_dec == '0) begin
                    phase_next = rcp_pkg::PH_TYPE_END;
                end
            end
            rcp_pkg::PH_TYPE_END: begin
                if (item.in_byte == rcp_pkg::CH_LF) begin
                    type_next  = type_found;
                    phase_next = rcp_pkg::PH_KLEN;
                    accum_next = '0;
                    left_next  = LB'(rcp_pkg::SUB_START);
                end
            end
            rcp_pkg::PH_KLEN: begin
                accum_next = ls.accum;
                left_next  = ls.sub;
                if (ls.done) begin
                    left_next  = ls.accum;
                    key_next   = '0;
                    phase_next = (ls.accum != '0) ? rcp_pkg::PH_KEY : rcp_pkg::PH_KEY_END;
                end
            end
            rcp_pkg::PH_KEY: begin
                if (is_digit) begin
                    key_next = (key_reg << 3) + (key_reg << 1)
                             + KB'(item.in_byte - rcp_pkg::CH_ZERO);
                end
                left_next = left_dec;
                if (left_dec == '0) begin
                    phase_next = rcp_pkg::PH_KEY_END;
                end
            end
            rcp_pkg::PH_KEY_END: begin
                if (item.in_byte == rcp_pkg::CH_LF) begin
                    key_next = key_plus;
                    if (type_reg >= rcp_pkg::CMD_GET) begin
                        do_complete = 1'b1;
                        done_key    = key_plus;
                    end else begin
                        phase_next = rcp_pkg::PH_VLEN;
                        accum_next = '0;
                        left_next  = LB'(rcp_pkg::SUB_START);
                    end
                end
            end
            rcp_pkg::PH_VLEN: begin
                accum_next = ls.accum;
                left_next  = ls.sub;
                if (ls.done) begin
                    vlen_next  = ls.accum;
                    left_next  = ls.accum;
                    phase_next = (ls.accum != '0) ? rcp_pkg::PH_VAL : rcp_pkg::PH_VAL_END;
                end
            end
            rcp_pkg::PH_VAL: begin
                left_next = left_dec;
                if (left_dec == '0) begin
                    phase_next = rcp_pkg::PH_VAL_END;
                end
            end
            rcp_pkg::PH_VAL_END: begin
                if (item.in_byte == rcp_pkg::CH_LF) begin
                    do_complete = 1'b1;
                end
            end
            default: begin
                if (phase_reg != rcp_pkg::PH_CNT) begin
                    phase_next = rcp_pkg::PH_CNT;
                    key_next   = '0;
                    match_next = 3'b111;
                    seen_next  = '0;
                    count_next = '0;
                    vlen_next  = '0;
                    type_next  = rcp_pkg::CMD_UNKNOWN;
                end
                accum_next = ls.accum;
                left_next  = ls.sub;
                if (ls.done) begin
                    count_next = ls.accum;
                    phase_next = rcp_pkg::PH_TLEN;
                    accum_next = '0;
                    left_next  = LB'(rcp_pkg::SUB_START);
                end
            end
        endcase
        if (do_complete) begin
            phase_next = rcp_pkg::PH_CNT;
            accum_next = '0;
            left_next  = LB'(rcp_pkg::SUB_START);
            key_next   = '0;
            match_next = 3'b111;
            seen_next  = '0;
            count_next = '0;
            vlen_next  = '0;
            type_next  = rcp_pkg::CMD_UNKNOWN;
        end
    end

    // result of this byte
    always_comb begin
        res       = '0;
        if (phase_reg == rcp_pkg::PH_VAL) begin
            res.valid           = 1'b1;
            res.data.kind       = rcp_pkg::KIND_DATA;
            res.data.value_byte = item.in_byte;
        end else if (do_complete) begin
            res.valid             = 1'b1;
            res.data.kind         = rcp_pkg::KIND_DONE;
            res.data.cmd_type     = type_reg;
            res.data.key_number   = done_key;
            res.data.arg_count    = 16'(count_reg);
            res.data.value_length = (type_reg >= rcp_pkg::CMD_GET) ? 16'd0 : 16'(vlen_reg);
            res.data.out_tag      = item.conn_tag;
        end else if (item.chunk_last
                     && !(phase_next == rcp_pkg::PH_CNT
                          && left_next == LB'(rcp_pkg::SUB_START))) begin
            res.valid        = 1'b1;
            res.data.kind    = rcp_pkg::KIND_PEND;
            res.data.out_tag = item.conn_tag;
        end
        res.valid = res.valid && step;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= rcp_pkg::PH_CNT;
            accum_reg <= '0;
            left_reg  <= '0;
            key_reg   <= '0;
            match_reg <= 3'b111;
            seen_reg  <= '0;
            count_reg <= '0;
            vlen_reg  <= '0;
            type_reg  <= rcp_pkg::CMD_UNKNOWN;
        end else if (step) begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
            left_reg  <= left_next;
            key_reg   <= key_next;
            match_reg <= match_next;
            seen_reg  <= seen_next;
            count_reg <= count_next;
            vlen_reg  <= vlen_next;
            type_reg  <= type_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rcp_out_stage.sv */
`default_nettype none

module rcp_out_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire rcp_pkg::res_t res,
    output logic               advance,
    output logic               m_valid,
    input  wire logic          m_ready,
    output rcp_pkg::out_t      m_payload
);

    logic          valid_reg;
    rcp_pkg::out_t data_reg;

    assign advance   = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign m_payload = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res.valid) begin
            data_reg <= res.data;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/resp_command_parser.sv */
`default_nettype none

// RESP command parser: takes one byte of a RESP array command per cycle and
// returns at most one result per byte: a value data byte, a command completion
// (type, key number, count, value length, tag) or a pending marker at a chunk
// end with a command still open. Every byte, including those that give no
// result, is accepted at one per cycle as long as the result register drains;
// a byte passes through the input register and then the parse step, which
// updates the command state and loads the result register.
// The parse state is updated once per byte, so throughput is bound only by
// back-pressure on the result channel.
module resp_command_parser (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire rcp_pkg::in_t  s_payload,
    output logic               m_valid,
    input  wire logic          m_ready,
    output rcp_pkg::out_t      m_payload
);

    logic          advance;
    logic          item_valid;
    rcp_pkg::in_t  item;
    rcp_pkg::res_t res;

    rcp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    rcp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (item_valid && advance),
        .item    (item),
        .res     (res)
    );

    rcp_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res       (res),
        .advance   (advance),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // input stalls only behind a blocked result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output back-pressure");

    a_data_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.kind == rcp_pkg::KIND_DATA |->
            m_payload.cmd_type == rcp_pkg::CMD_UNKNOWN && m_payload.key_number == 64'd0
            && m_payload.out_tag == 8'd0)
        else $error("data result carries completion fields");

    a_no_vlen_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.kind == rcp_pkg::KIND_DONE
            && (m_payload.cmd_type == rcp_pkg::CMD_GET || m_payload.cmd_type == rcp_pkg::CMD_DEL)
            |-> m_payload.value_length == 16'd0)
        else $error("read or delete completion with value length");

    a_pend_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.kind == rcp_pkg::KIND_PEND |->
            m_payload.value_byte == 8'd0 && m_payload.key_number == 64'd0
            && m_payload.arg_count == 16'd0)
        else $error("pending result carries request fields");

endmodule

`default_nettype wire

/* verif/resp_command_parser_chk.sv */
`timescale 1ns / 100ps

module resp_command_parser_chk (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    input  wire logic          s_ready,
    input  wire rcp_pkg::in_t  s_payload,
    input  wire logic          m_valid,
    input  wire logic          m_ready,
    input  wire rcp_pkg::out_t m_payload,
    output int                 fail_count,
    output int                 outstanding,
    output logic               parse_idle,
    output logic               need_cr
);
    import rcp_pkg::*;

    localparam logic [71:0] TYPE_WORDS = {"SET", "GET", "DEL"};

    phase_t      stage;
    logic [15:0] num_acc;
    logic [15:0] remain;
    logic [63:0] key_sum;
    logic [2:0]  word_alive;
    logic [15:0] word_len;
    logic [15:0] count_reg;
    logic [15:0] vlen_reg;
    logic [1:0]  cmd_reg;

    out_t parsed_q[$];
    out_t next_res;
    out_t oldest;
    bit   got_res;
    int   errors = 0;

    function automatic void clear_command();
        stage = PH_CNT;
        num_acc = '0;
        remain = 16'(SUB_START);
        key_sum = '0;
        word_alive = 3'b111;
        word_len = '0;
        count_reg = '0;
        vlen_reg = '0;
        cmd_reg = CMD_UNKNOWN;
    endfunction

    function automatic void start_length(input phase_t nxt);
        stage = nxt;
        num_acc = '0;
        remain = 16'(SUB_START);
    endfunction

    // returns 1 when the decimal length field is closed
    function automatic bit length_done(input logic [7:0] b, input logic [7:0] marker);
        if (remain == SUB_START && b == CH_LF) return 1'b1;
        if (remain == SUB_START && b == marker) begin
            remain = 16'(SUB_DIGITS);
            return 1'b0;
        end
        if (b == CH_CR) begin
            remain = 16'(SUB_CR);
            return 1'b0;
        end
        if (remain == SUB_CR && b == CH_LF) return 1'b1;
        num_acc = num_acc * 16'd10 + {8'd0, b} - 16'd48;
        remain = 16'(SUB_DIGITS);
        return 1'b0;
    endfunction

    function automatic out_t finish_command(input logic [7:0] tag);
        out_t r;
        r = '0;
        r.kind = KIND_DONE;
        r.cmd_type = cmd_reg;
        r.key_number = key_sum;
        r.arg_count = count_reg;
        r.value_length = (cmd_reg >= CMD_GET) ? 16'd0 : vlen_reg;
        r.out_tag = tag;
        clear_command();
        return r;
    endfunction

    task automatic parse_byte(input in_t req, output bit got, output out_t r);
        logic [7:0] b;
        b = req.in_byte;
        got = 1'b0;
        r = '0;
        case (stage)
            PH_TLEN: begin
                if (length_done(b, CH_DOLLAR)) begin
                    remain = num_acc;
                    word_len = '0;
                    word_alive = 3'b111;
                    stage = (remain != 0) ? PH_TYPE : PH_TYPE_END;
                end
            end
            PH_TYPE: begin
                if (word_len < 3) begin
                    for (int i = 0; i < 3; i++) begin
                        if (TYPE_WORDS[8 * (8 - 3 * i - int'(word_len)) +: 8] != b)
                            word_alive[i] = 1'b0;
                    end
                end
                if (word_len != 16'hffff) word_len++;
                remain--;
                if (remain == 0) stage = PH_TYPE_END;
            end
            PH_TYPE_END: begin
                if (b == CH_LF) begin
                    cmd_reg = CMD_UNKNOWN;
                    if (word_len == 3) begin
                        for (int i = 2; i >= 0; i--) begin
                            if (word_alive[i]) cmd_reg = 2'(i + 1);
                        end
                    end
                    start_length(PH_KLEN);
                end
            end
            PH_KLEN: begin
                if (length_done(b, CH_DOLLAR)) begin
                    remain = num_acc;
                    key_sum = '0;
                    stage = (remain != 0) ? PH_KEY : PH_KEY_END;
                end
            end
            PH_KEY: begin
                if (b >= CH_ZERO && b <= CH_NINE)
                    key_sum = key_sum * 64'd10 + 64'(b - CH_ZERO);
                remain--;
                if (remain == 0) stage = PH_KEY_END;
            end
            PH_KEY_END: begin
                if (b == CH_LF) begin
                    key_sum = key_sum + 64'd1;
                    if (cmd_reg >= CMD_GET) begin
                        r = finish_command(req.conn_tag);
                        got = 1'b1;
                    end else begin
                        start_length(PH_VLEN);
                    end
                end
            end
            PH_VLEN: begin
                if (length_done(b, CH_DOLLAR)) begin
                    vlen_reg = num_acc;
                    remain = num_acc;
                    stage = (remain != 0) ? PH_VAL : PH_VAL_END;
                end
            end
            PH_VAL: begin
                remain--;
                if (remain == 0) stage = PH_VAL_END;
                r.kind = KIND_DATA;
                r.value_byte = b;
                got = 1'b1;
            end
            PH_VAL_END: begin
                if (b == CH_LF) begin
                    r = finish_command(req.conn_tag);
                    got = 1'b1;
                end
            end
            default: begin
                if (length_done(b, CH_STAR)) begin
                    count_reg = num_acc;
                    start_length(PH_TLEN);
                end
            end
        endcase
        // chunk end with a command still open
        if (!got && req.chunk_last && !(stage == PH_CNT && remain == SUB_START)) begin
            r.kind = KIND_PEND;
            r.out_tag = req.conn_tag;
            got = 1'b1;
        end
    endtask

    function automatic int field_bad(input string name, input logic [63:0] want,
                                     input logic [63:0] seen);
        if (want !== seen) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, seen);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_command();
            parsed_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (parsed_q.size() == 0) begin
                    $error("result with none expected: kind %0d", m_payload.kind);
                    errors++;
                end else begin
                    oldest = parsed_q.pop_front();
                    if ((field_bad("kind", oldest.kind, m_payload.kind)
                         + field_bad("value_byte", oldest.value_byte, m_payload.value_byte)
                         + field_bad("cmd_type", oldest.cmd_type, m_payload.cmd_type)
                         + field_bad("key_number", oldest.key_number, m_payload.key_number)
                         + field_bad("arg_count", oldest.arg_count, m_payload.arg_count)
                         + field_bad("value_length", oldest.value_length,
                                     m_payload.value_length)
                         + field_bad("out_tag", oldest.out_tag, m_payload.out_tag)) != 0)
                        errors++;
                end
            end
            if (s_valid && s_ready) begin
                parse_byte(s_payload, got_res, next_res);
                if (got_res) parsed_q.push_back(next_res);
            end
        end
        fail_count <= errors;
        outstanding <= parsed_q.size();
        parse_idle <= (stage == PH_CNT && remain == SUB_START);
        need_cr <= (stage == PH_CNT || stage == PH_TLEN || stage == PH_KLEN
                    || stage == PH_VLEN) && remain != SUB_CR;
    end

endmodule

/* verif/resp_command_parser_tb.sv */
`timescale 1ns / 100ps

module resp_command_parser_tb;
    import rcp_pkg::*;

    typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_MOSTLY, RDY_PERIODIC} ready_mode_t;

    localparam logic [23:0] WORD_SET = "SET";
    localparam logic [23:0] WORD_GET = "GET";
    localparam logic [23:0] WORD_DEL = "DEL";
    localparam logic [47:0] TYPE_LETTERS = "SETGDL";
    localparam int ITEM_TARGET = 1550;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_payload = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_payload;

    int   fail_count;
    int   outstanding;
    logic parse_idle;
    logic need_cr;

    logic [7:0]  cmd_bytes[$];
    int          burst_left = 0;
    int          sent = 0;
    ready_mode_t ready_mode = RDY_ALWAYS;
    int          mode_left = 0;
    int unsigned ready_tick = 0;
    bit          allow_wrap = 1'b1;

    resp_command_parser u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    resp_command_parser_chk u_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_payload   (s_payload),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_payload   (m_payload),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .parse_idle  (parse_idle),
        .need_cr     (need_cr)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    always @(posedge aclk) begin
        if (mode_left == 0) begin
            ready_mode <= ready_mode_t'($urandom_range(0, 3));
            mode_left <= $urandom_range(20, 400);
        end else begin
            mode_left <= mode_left - 1;
        end
        ready_tick <= ready_tick + 1;
        case (ready_mode)
            RDY_ALWAYS: m_ready <= 1'b1;
            RDY_COIN:   m_ready <= 1'($urandom_range(0, 1));
            RDY_MOSTLY: m_ready <= ($urandom_range(0, 7) != 0);
            default:    m_ready <= (ready_tick % 11) < 4;
        endcase
    end

    task automatic send_byte(input logic [7:0] b, input logic last, input logic [7:0] tag);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 48);
        end
        s_valid <= 1'b1;
        s_payload <= '{in_byte: b, chunk_last: last, conn_tag: tag};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        sent++;
    endtask

    // last_at below zero: random chunk ends and occasional foreign tags
    task automatic send_queue(input logic [7:0] tag, input int last_at);
        logic       last;
        logic [7:0] t;
        foreach (cmd_bytes[i]) begin
            if (last_at >= 0) begin
                last = (i == last_at);
                t = tag;
            end else begin
                last = ($urandom_range(0, 15) == 0);
                t = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : tag;
            end
            send_byte(cmd_bytes[i], last, t);
        end
        cmd_bytes.delete();
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        burst_left = 0;
    endtask

    // close whatever request sequence the parser is in, using CR/LF only
    task automatic resync_parser(input logic [7:0] tag);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (!parse_idle) begin
            send_byte(need_cr ? CH_CR : CH_LF, ($urandom_range(0, 7) == 0), tag);
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        burst_left = 0;
    endtask

    function automatic void push_length(input logic [7:0] marker, input int unsigned eff);
        int unsigned declared;
        logic [7:0]  digits[$];
        declared = eff;
        if (eff == 0 && $urandom_range(0, 3) == 0) begin
            cmd_bytes.push_back(CH_LF);
            return;
        end
        // wraps back to eff in 16 bits
        if (allow_wrap && $urandom_range(0, 19) == 0)
            declared = eff + 32'd65536 * $urandom_range(1, 3);
        if ($urandom_range(0, 9) != 0) cmd_bytes.push_back(marker);
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) cmd_bytes.push_back(CH_ZERO);
        do begin
            digits.push_front(CH_ZERO + 8'(declared % 10));
            declared = declared / 10;
        end while (declared != 0);
        foreach (digits[i]) cmd_bytes.push_back(digits[i]);
        cmd_bytes.push_back(CH_CR);
        cmd_bytes.push_back(CH_LF);
    endfunction

    function automatic void push_end();
        case ($urandom_range(0, 5))
            0: cmd_bytes.push_back(CH_LF);
            1: begin
                cmd_bytes.push_back(8'($urandom_range(65, 90)));
                cmd_bytes.push_back(CH_CR);
                cmd_bytes.push_back(CH_LF);
            end
            default: begin
                cmd_bytes.push_back(CH_CR);
                cmd_bytes.push_back(CH_LF);
            end
        endcase
    endfunction

    function automatic void build_command();
        logic [7:0]  word[$];
        logic [23:0] w;
        int          pick;
        int          n;
        bit          no_value;
        push_length(CH_STAR, ($urandom_range(0, 15) == 0) ? $urandom_range(0, 300000)
                                                          : $urandom_range(2, 4));
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
            if (pick < 3) w = WORD_SET;
            else if (pick < 5) w = WORD_GET;
            else if (pick < 7) w = WORD_DEL;
            else begin
                for (int k = 0; k < 3; k++)
                    w[8 * k +: 8] = TYPE_LETTERS[8 * $urandom_range(0, 5) +: 8];
            end
            word.push_back(w[23:16]);
            word.push_back(w[15:8]);
            word.push_back(w[7:0]);
        end else begin
            repeat ($urandom_range(0, 6)) word.push_back(8'($urandom_range(0, 255)));
        end
        no_value = (word.size() == 3)
                   && ({word[0], word[1], word[2]} == WORD_GET
                       || {word[0], word[1], word[2]} == WORD_DEL);
        push_length(CH_DOLLAR, word.size());
        foreach (word[i]) cmd_bytes.push_back(word[i]);
        push_end();
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
        push_length(CH_DOLLAR, n);
        repeat (n) begin
            cmd_bytes.push_back(($urandom_range(0, 7) != 0) ? CH_ZERO + 8'($urandom_range(0, 9))
                                                            : 8'($urandom_range(0, 255)));
        end
        push_end();
        if (!no_value) begin
            n = ($urandom_range(0, 39) == 0) ? $urandom_range(50, 200) : $urandom_range(0, 10);
            push_length(CH_DOLLAR, n);
            repeat (n) cmd_bytes.push_back(8'($urandom_range(0, 255)));
            push_end();
        end
    endfunction

    initial begin
        int         pick;
        int         keep;
        int         last_drain;
        logic [7:0] tag;
        last_drain = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty command made of bare line ends, count field opening with CR
        cmd_bytes = '{CH_CR, CH_LF, CH_LF, CH_LF, CH_LF, CH_LF, CH_LF, CH_LF};
        send_queue(8'hff, 7);
        // DEL with a digit after CR in the count, chunk end inside the word
        cmd_bytes = '{CH_STAR, "1", CH_CR, "2", CH_CR, CH_LF, "3", CH_CR, CH_LF,
                      "D", "E", "L", CH_LF, "2", CH_CR, CH_LF, 8'h00, "9", CH_LF};
        send_queue(8'h00, 10);
        // SET with one 0xff value byte that also ends the chunk
        cmd_bytes = '{CH_LF, "3", CH_CR, CH_LF, "S", "E", "T", CH_LF, CH_LF, CH_LF,
                      "1", CH_CR, CH_LF, 8'hff, CH_LF};
        send_queue(8'h5a, 13);
        drain_results();

        while (sent < ITEM_TARGET) begin
            tag = 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
                build_command();
                send_queue(tag, -1);
            end else if (pick == 8) begin
                // a cut inside a wrapped length would leave a huge field to flush
                allow_wrap = 1'b0;
                build_command();
                allow_wrap = 1'b1;
                keep = $urandom_range(1, cmd_bytes.size() - 1);
                while (cmd_bytes.size() > keep) void'(cmd_bytes.pop_back());
                send_queue(tag, -1);
                resync_parser(tag);
            end else begin
                cmd_bytes.push_back(($urandom_range(0, 1) != 0) ? CH_STAR : CH_DOLLAR);
                repeat ($urandom_range(0, 2)) begin
                    case ($urandom_range(0, 3))
                        0: cmd_bytes.push_back(CH_CR);
                        1: cmd_bytes.push_back(CH_LF);
                        2: cmd_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 3)));
                        default: cmd_bytes.push_back(8'($urandom_range(65, 70)));
                    endcase
                end
                send_queue(tag, -1);
                resync_parser(tag);
            end
            if (sent - last_drain > 400) begin
                drain_results();
                last_drain = sent;
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/rcp_pkg.sv
hw/rtl/rcp_in_stage.sv
hw/rtl/rcp_core.sv
hw/rtl/rcp_out_stage.sv
hw/rtl/resp_command_parser.sv
verif/resp_command_parser_chk.sv
verif/resp_command_parser_tb.sv
